// ===== sv/ewq_pkg.sv =====
// Shared constants, codes and command types of the event wait queue manager.
`timescale 1ns / 1ps
`default_nettype none

package ewq_pkg;

  localparam int NUM_TYPES = 8;
  localparam int NUM_SLOTS = 16;

  localparam int EV_W     = 8;
  localparam int TASK_W   = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  localparam logic [EV_W-1:0]   EV_LIMIT  = EV_W'(NUM_TYPES);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED    = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_FULL      = 3'd2,
    ST_WOKEN     = 3'd3,
    ST_WOKEN_Z   = 3'd4,
    ST_NO_WAITER = 3'd5
  } status_t;

  // Write and read requests into the slot store.
  typedef struct packed {
    logic              busy_we;
    logic              busy_val;
    logic [SLOT_W-1:0] idx;
    logic              task_we;
    logic [TASK_W-1:0] task_id;
    logic              link_we;
    logic [SLOT_W-1:0] link_idx;
    logic [SLOT_W-1:0] link_val;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
  } slot_cmd_t;

  // Write and read requests into the queue table.
  typedef struct packed {
    logic              rd_en;
    logic [TYPE_W-1:0] rd_idx;
    logic [TYPE_W-1:0] wr_idx;
    logic              ne_we;
    logic              ne_val;
    logic              first_we;
    logic [SLOT_W-1:0] first_val;
    logic              last_we;
    logic [SLOT_W-1:0] last_val;
  } queue_cmd_t;

endpackage

`default_nettype wire

// ===== sv/ewq_slot_store.sv =====
// Wait slot pool: busy flags, task id memory and link memory.
`timescale 1ns / 1ps
`default_nettype none

module ewq_slot_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ewq_pkg::slot_cmd_t        cmd,
  output logic [ewq_pkg::NUM_SLOTS-1:0]  busy,
  output logic [ewq_pkg::TASK_W-1:0]     rd_task,
  output logic [ewq_pkg::SLOT_W-1:0]     rd_link
);

  logic [ewq_pkg::NUM_SLOTS-1:0] busy_r;
  logic [ewq_pkg::TASK_W-1:0]    task_mem [ewq_pkg::NUM_SLOTS];
  logic [ewq_pkg::SLOT_W-1:0]    link_mem [ewq_pkg::NUM_SLOTS];
  logic [ewq_pkg::TASK_W-1:0]    rd_task_r;
  logic [ewq_pkg::SLOT_W-1:0]    rd_link_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (cmd.busy_we) begin
      busy_r[cmd.idx] <= cmd.busy_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.task_we) begin
      task_mem[cmd.idx] <= cmd.task_id;
    end
    if (cmd.link_we) begin
      link_mem[cmd.link_idx] <= cmd.link_val;
    end
    if (cmd.rd_en) begin
      rd_task_r <= task_mem[cmd.rd_idx];
      rd_link_r <= link_mem[cmd.rd_idx];
    end
  end

  assign busy    = busy_r;
  assign rd_task = rd_task_r;
  assign rd_link = rd_link_r;

endmodule

`default_nettype wire

// ===== sv/ewq_queue_table.sv =====
// Per event type queue heads, tails and nonempty flags.
`timescale 1ns / 1ps
`default_nettype none

module ewq_queue_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ewq_pkg::queue_cmd_t       cmd,
  output logic [ewq_pkg::NUM_TYPES-1:0]  nonempty,
  output logic [ewq_pkg::SLOT_W-1:0]     rd_first,
  output logic [ewq_pkg::SLOT_W-1:0]     rd_last
);

  logic [ewq_pkg::NUM_TYPES-1:0] nonempty_r;
  logic [ewq_pkg::SLOT_W-1:0]    first_mem [ewq_pkg::NUM_TYPES];
  logic [ewq_pkg::SLOT_W-1:0]    last_mem  [ewq_pkg::NUM_TYPES];
  logic [ewq_pkg::SLOT_W-1:0]    rd_first_r;
  logic [ewq_pkg::SLOT_W-1:0]    rd_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
    end else if (cmd.ne_we) begin
      nonempty_r[cmd.wr_idx] <= cmd.ne_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first_we) begin
      first_mem[cmd.wr_idx] <= cmd.first_val;
    end
    if (cmd.last_we) begin
      last_mem[cmd.wr_idx] <= cmd.last_val;
    end
    if (cmd.rd_en) begin
      rd_first_r <= first_mem[cmd.rd_idx];
      rd_last_r  <= last_mem[cmd.rd_idx];
    end
  end

  assign nonempty = nonempty_r;
  assign rd_first = rd_first_r;
  assign rd_last  = rd_last_r;

endmodule

`default_nettype wire

// ===== sv/event_wait_queue_manager_core.sv =====
// Top level of the event wait queue manager: sequencer, free slot scan, result register.
//
// Keeps a pool of wait slots linked into one FIFO per event type. An await
// word (action 0) takes the lowest free slot, stores the task id and appends
// the slot to its type's queue; an event word (action 1) pops the oldest
// waiter of its type and returns its task id with the value (status 4 when
// the value is zero). One word is handled at a time. The free slot search
// steps one slot per cycle through a single compare, and a full pool is
// reported once the last slot has been found busy. An event first reads
// the queue table and then the slot store, both registered reads, before
// the head slot is freed. Bad ids and empty queues report straight from
// the accept, with no scan. A result waiting in the output register does
// not stop the next word from being accepted.
`timescale 1ns / 1ps
`default_nettype none

module event_wait_queue_manager_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_action,
  input  wire logic [ewq_pkg::EV_W-1:0]       in_event_id,
  input  wire logic [ewq_pkg::TASK_W-1:0]     in_task_id,
  input  wire logic [ewq_pkg::VAL_W-1:0]      in_event_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ewq_pkg::STATUS_W-1:0]        out_status,
  output logic [ewq_pkg::TASK_W-1:0]          out_woken_task,
  output logic [ewq_pkg::VAL_W-1:0]           out_wake_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ewq_pkg::TYPE_W-1:0]    ev_r, ev_nxt;
  logic [ewq_pkg::TASK_W-1:0]    task_r, task_nxt;
  logic [ewq_pkg::VAL_W-1:0]     val_r, val_nxt;
  logic [ewq_pkg::SLOT_W-1:0]    scan_r, scan_nxt;
  ewq_pkg::status_t              res_status_r, res_status_nxt;
  logic [ewq_pkg::TASK_W-1:0]    res_task_r, res_task_nxt;
  logic [ewq_pkg::VAL_W-1:0]     res_value_r, res_value_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ewq_pkg::status_t              out_status_r, out_status_nxt;
  logic [ewq_pkg::TASK_W-1:0]    out_task_r, out_task_nxt;
  logic [ewq_pkg::VAL_W-1:0]     out_value_r, out_value_nxt;

  ewq_pkg::slot_cmd_t            slot_cmd;
  ewq_pkg::queue_cmd_t           queue_cmd;
  logic [ewq_pkg::NUM_SLOTS-1:0] busy;
  logic [ewq_pkg::TASK_W-1:0]    rd_task;
  logic [ewq_pkg::SLOT_W-1:0]    rd_link;
  logic [ewq_pkg::NUM_TYPES-1:0] nonempty;
  logic [ewq_pkg::SLOT_W-1:0]    q_first;
  logic [ewq_pkg::SLOT_W-1:0]    q_last;
  logic [ewq_pkg::TYPE_W-1:0]    in_type;
  logic [ewq_pkg::TYPE_W-1:0]    cur_type;

  assign in_type  = in_event_id[ewq_pkg::TYPE_W-1:0];
  assign cur_type = ev_r;
  assign in_ready = (state_r == S_IDLE);

  ewq_slot_store u_slot_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (slot_cmd),
    .busy    (busy),
    .rd_task (rd_task),
    .rd_link (rd_link)
  );

  ewq_queue_table u_queue_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (queue_cmd),
    .nonempty (nonempty),
    .rd_first (q_first),
    .rd_last  (q_last)
  );

  always_comb begin
    state_nxt      = state_r;
    ev_nxt         = ev_r;
    task_nxt       = task_r;
    val_nxt        = val_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_task_nxt   = res_task_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_value_nxt  = out_value_r;
    slot_cmd       = '0;
    queue_cmd      = '0;
    queue_cmd.wr_idx = cur_type;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ev_nxt   = in_type;
          task_nxt = in_task_id;
          val_nxt  = in_event_value;
          queue_cmd.rd_en  = 1'b1;
          queue_cmd.rd_idx = in_type;
          res_task_nxt  = '0;
          res_value_nxt = '0;
          if (in_event_id >= ewq_pkg::EV_LIMIT) begin
            res_status_nxt = ewq_pkg::ST_BAD_ID;
            state_nxt      = S_DONE;
          end else if (!in_action) begin
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end else if (!nonempty[in_type]) begin
            res_status_nxt = ewq_pkg::ST_NO_WAITER;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_POP_RD;
          end
        end
      end

      S_SCAN: begin
        // Step the busy compare one slot per cycle; take the first free one.
        if (!busy[scan_r]) begin
          slot_cmd.busy_we  = 1'b1;
          slot_cmd.busy_val = 1'b1;
          slot_cmd.idx      = scan_r;
          slot_cmd.task_we  = 1'b1;
          slot_cmd.task_id  = task_r;
          queue_cmd.last_we  = 1'b1;
          queue_cmd.last_val = scan_r;
          if (nonempty[cur_type]) begin
            slot_cmd.link_we  = 1'b1;
            slot_cmd.link_idx = q_last;
            slot_cmd.link_val = scan_r;
          end else begin
            queue_cmd.first_we  = 1'b1;
            queue_cmd.first_val = scan_r;
            queue_cmd.ne_we     = 1'b1;
            queue_cmd.ne_val    = 1'b1;
          end
          res_status_nxt = ewq_pkg::ST_QUEUED;
          state_nxt      = S_DONE;
        end else if (scan_r == ewq_pkg::SLOT_LAST) begin
          res_status_nxt = ewq_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_POP_RD: begin
        slot_cmd.rd_en  = 1'b1;
        slot_cmd.rd_idx = q_first;
        state_nxt       = S_POP_WR;
      end

      S_POP_WR: begin
        // Free the head slot and advance or empty the queue.
        slot_cmd.busy_we  = 1'b1;
        slot_cmd.busy_val = 1'b0;
        slot_cmd.idx      = q_first;
        if (q_first == q_last) begin
          queue_cmd.ne_we  = 1'b1;
          queue_cmd.ne_val = 1'b0;
        end else begin
          queue_cmd.first_we  = 1'b1;
          queue_cmd.first_val = rd_link;
        end
        res_task_nxt = rd_task;
        if (val_r == '0) begin
          res_status_nxt = ewq_pkg::ST_WOKEN_Z;
          res_value_nxt  = '0;
        end else begin
          res_status_nxt = ewq_pkg::ST_WOKEN;
          res_value_nxt  = val_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_task_nxt   = res_task_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ev_r         <= ev_nxt;
    task_r       <= task_nxt;
    val_r        <= val_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_task_r   <= res_task_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_woken_task = out_task_r;
  assign out_wake_value = out_value_r;

endmodule

`default_nettype wire
